// File: src/bva_pkg.sv
// Package for the bit-vector ALU: sizes, opcodes and bit-count helpers.
package bva_pkg;

    // Sizes
    localparam int MAX_WIDTH = 64;
    localparam int DATA_W    = 64;
    localparam int WIDTH_W   = $clog2(DATA_W + 1);
    localparam int SHAMT_W   = $clog2(DATA_W);
    localparam int OP_W      = 5;
    localparam int IDX_W     = 6;

    // Stream payload sizes (tdata padded to whole bytes)
    localparam int S_FIELDS_W = OP_W + WIDTH_W + 2 * DATA_W + 2 * IDX_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = DATA_W + WIDTH_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Opcodes
    localparam logic [OP_W-1:0] OP_ADD     = 5'd0;
    localparam logic [OP_W-1:0] OP_SUB     = 5'd1;
    localparam logic [OP_W-1:0] OP_INC     = 5'd2;
    localparam logic [OP_W-1:0] OP_DEC     = 5'd3;
    localparam logic [OP_W-1:0] OP_NOT     = 5'd4;
    localparam logic [OP_W-1:0] OP_NEG     = 5'd5;
    localparam logic [OP_W-1:0] OP_AND     = 5'd6;
    localparam logic [OP_W-1:0] OP_NAND    = 5'd7;
    localparam logic [OP_W-1:0] OP_OR      = 5'd8;
    localparam logic [OP_W-1:0] OP_NOR     = 5'd9;
    localparam logic [OP_W-1:0] OP_XOR     = 5'd10;
    localparam logic [OP_W-1:0] OP_XNOR    = 5'd11;
    localparam logic [OP_W-1:0] OP_REDAND  = 5'd12;
    localparam logic [OP_W-1:0] OP_REDOR   = 5'd13;
    localparam logic [OP_W-1:0] OP_ULT     = 5'd14;
    localparam logic [OP_W-1:0] OP_ULE     = 5'd15;
    localparam logic [OP_W-1:0] OP_UGT     = 5'd16;
    localparam logic [OP_W-1:0] OP_UGE     = 5'd17;
    localparam logic [OP_W-1:0] OP_SLT     = 5'd18;
    localparam logic [OP_W-1:0] OP_SLE     = 5'd19;
    localparam logic [OP_W-1:0] OP_SGT     = 5'd20;
    localparam logic [OP_W-1:0] OP_SGE     = 5'd21;
    localparam logic [OP_W-1:0] OP_EQ      = 5'd22;
    localparam logic [OP_W-1:0] OP_NE      = 5'd23;
    localparam logic [OP_W-1:0] OP_IMPLIES = 5'd24;
    localparam logic [OP_W-1:0] OP_SHL     = 5'd25;
    localparam logic [OP_W-1:0] OP_LSHR    = 5'd26;
    localparam logic [OP_W-1:0] OP_ASHR    = 5'd27;
    localparam logic [OP_W-1:0] OP_CLZ     = 5'd28;
    localparam logic [OP_W-1:0] OP_CLO     = 5'd29;
    localparam logic [OP_W-1:0] OP_CTZ     = 5'd30;
    localparam logic [OP_W-1:0] OP_EXTRACT = 5'd31;

    // Low w bits set; w of DATA_W or more gives all ones
    function automatic logic [DATA_W-1:0] width_mask(input logic [WIDTH_W-1:0] w);
        logic [DATA_W-1:0] m;
        if (w >= WIDTH_W'(DATA_W)) begin
            m = '1;
        end else begin
            m = (DATA_W'(1) << w) - DATA_W'(1);
        end
        return m;
    endfunction

    // Leading zero count of a full word: per-byte counts, then a byte pick
    function automatic logic [WIDTH_W-1:0] lzc_word(input logic [DATA_W-1:0] x);
        logic [3:0]         grp_cnt [DATA_W/8];
        logic [DATA_W/8-1:0] grp_zero;
        logic [7:0]         byte_v;
        logic [WIDTH_W-1:0] n;
        logic               found;
        for (int g = 0; g < DATA_W / 8; g++) begin
            byte_v      = x[g*8 +: 8];
            grp_cnt[g]  = 4'd8;
            for (int i = 0; i < 8; i++) begin
                if (byte_v[i]) begin
                    grp_cnt[g] = 4'(7 - i);
                end
            end
            grp_zero[g] = (byte_v == 8'd0);
        end
        n     = WIDTH_W'(DATA_W);
        found = 1'b0;
        for (int g = DATA_W / 8 - 1; g >= 0; g--) begin
            if (!found && !grp_zero[g]) begin
                n     = WIDTH_W'((DATA_W / 8 - 1 - g) * 8) + WIDTH_W'(grp_cnt[g]);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // Bit reversal, used to turn a trailing count into a leading count
    function automatic logic [DATA_W-1:0] bit_rev(input logic [DATA_W-1:0] x);
        logic [DATA_W-1:0] y;
        for (int i = 0; i < DATA_W; i++) begin
            y[i] = x[DATA_W-1-i];
        end
        return y;
    endfunction

endpackage

// File: src/bitvector_alu_unit.sv
// Bit-vector ALU: three-stage pipeline with stream handshakes on both sides.
// Each item passes the stage 1, 2 and 3 registers in order to the output.
// Throughput: one per cycle; a stage stalls only when the stage after
// it is full and held.
// Reset (i_rst_n low, synchronous) empties all stages; data registers keep.
// Stages: width clamp and masking, operation units, result select and mask.
module bitvector_alu_unit
    import bva_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [4:0] operation, [11:5] operand_width, [75:12] operand_a,
    // [139:76] operand_b, [145:140] field_high, [151:146] field_low
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // Output stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [63:0] result_value, [70:64] result_width, [71] zero
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    // Input field positions
    localparam int OP_LSB = 0;
    localparam int W_LSB  = OP_LSB + OP_W;
    localparam int A_LSB  = W_LSB + WIDTH_W;
    localparam int B_LSB  = A_LSB + DATA_W;
    localparam int HI_LSB = B_LSB + DATA_W;
    localparam int LO_LSB = HI_LSB + IDX_W;

    // Stage valids and advance terms
    logic r1_v, r2_v, r3_v;
    logic rdy1, rdy2, rdy3;

    assign rdy3       = !r3_v || i_m_tready;
    assign rdy2       = !r2_v || rdy3;
    assign rdy1       = !r1_v || rdy2;
    assign o_s_tready = rdy1;
    assign o_m_tvalid = r3_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (rdy1) r1_v <= i_s_tvalid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
        end
    end

    // ---------------- Stage 1: width clamp, operand masking ----------------
    logic [OP_W-1:0]    in_op;
    logic [WIDTH_W-1:0] in_w;
    logic [IDX_W-1:0]   in_hi, in_lo;
    logic [WIDTH_W-1:0] n1_w;
    logic [DATA_W-1:0]  n1_m;

    assign in_op = i_s_tdata[OP_LSB +: OP_W];
    assign in_w  = i_s_tdata[W_LSB +: WIDTH_W];
    assign in_hi = i_s_tdata[HI_LSB +: IDX_W];
    assign in_lo = i_s_tdata[LO_LSB +: IDX_W];

    always_comb begin
        if (in_w == '0) begin
            n1_w = WIDTH_W'(1);
        end else if (in_w > WIDTH_W'(MAX_WIDTH)) begin
            n1_w = WIDTH_W'(MAX_WIDTH);
        end else begin
            n1_w = in_w;
        end
        n1_m = width_mask(n1_w);
    end

    logic [OP_W-1:0]    r1_op;
    logic [WIDTH_W-1:0] r1_w;
    logic [DATA_W-1:0]  r1_m, r1_sb, r1_a, r1_b;
    logic [IDX_W-1:0]   r1_hi, r1_lo;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_op <= in_op;
            r1_w  <= n1_w;
            r1_m  <= n1_m;
            r1_sb <= DATA_W'(1) << (n1_w - WIDTH_W'(1));
            r1_a  <= i_s_tdata[A_LSB +: DATA_W] & n1_m;
            r1_b  <= i_s_tdata[B_LSB +: DATA_W] & n1_m;
            r1_hi <= in_hi;
            r1_lo <= in_lo;
        end
    end

    // ---------------- Stage 2: operation units ----------------
    logic [DATA_W-1:0]  n2_arith, n2_logic, n2_shift, n2_ext;
    logic [WIDTH_W-1:0] n2_cnt, n2_rw;
    logic               n2_flag;

    always_comb begin
        logic [DATA_W-1:0]  add_x, add_y, cnt_src, shr_v;
        logic               add_ci, big, neg, lt_u, lt_s, eq;
        logic [WIDTH_W-1:0] lz, tz, hi_c, lo_w;
        logic [SHAMT_W-1:0] sh;

        // Shared adder for add, sub, inc, dec, neg
        add_x  = r1_a;
        add_y  = r1_b;
        add_ci = 1'b0;
        case (r1_op)
            OP_SUB: begin
                add_y  = ~r1_b;
                add_ci = 1'b1;
            end
            OP_INC: begin
                add_y  = '0;
                add_ci = 1'b1;
            end
            OP_DEC: begin
                add_y  = '1;
            end
            OP_NEG: begin
                add_x  = '0;
                add_y  = ~r1_a;
                add_ci = 1'b1;
            end
            default: begin
                add_y  = r1_b;
            end
        endcase
        n2_arith = add_x + add_y + DATA_W'(add_ci);

        // Bitwise logic
        case (r1_op)
            OP_NOT:  n2_logic = ~r1_a;
            OP_AND:  n2_logic = r1_a & r1_b;
            OP_NAND: n2_logic = ~(r1_a & r1_b);
            OP_OR:   n2_logic = r1_a | r1_b;
            OP_NOR:  n2_logic = ~(r1_a | r1_b);
            OP_XOR:  n2_logic = r1_a ^ r1_b;
            default: n2_logic = ~(r1_a ^ r1_b);
        endcase

        // Compares, reductions and implies; signed compare flips the sign bit
        lt_u = r1_a < r1_b;
        lt_s = (r1_a ^ r1_sb) < (r1_b ^ r1_sb);
        eq   = r1_a == r1_b;
        case (r1_op)
            OP_REDAND:  n2_flag = r1_a == r1_m;
            OP_REDOR:   n2_flag = r1_a != '0;
            OP_ULT:     n2_flag = lt_u;
            OP_ULE:     n2_flag = lt_u || eq;
            OP_UGT:     n2_flag = !(lt_u || eq);
            OP_UGE:     n2_flag = !lt_u;
            OP_SLT:     n2_flag = lt_s;
            OP_SLE:     n2_flag = lt_s || eq;
            OP_SGT:     n2_flag = !(lt_s || eq);
            OP_SGE:     n2_flag = !lt_s;
            OP_EQ:      n2_flag = eq;
            OP_NE:      n2_flag = !eq;
            default:    n2_flag = !r1_a[0] || r1_b[0];
        endcase

        // Shifts; an amount of w or more saturates
        sh    = r1_b[SHAMT_W-1:0];
        big   = r1_b >= DATA_W'(r1_w);
        neg   = (r1_a & r1_sb) != '0;
        shr_v = neg ? ~((~r1_a & r1_m) >> sh) : (r1_a >> sh);
        case (r1_op)
            OP_SHL:  n2_shift = big ? '0 : (r1_a << sh);
            OP_LSHR: n2_shift = big ? '0 : (r1_a >> sh);
            default: n2_shift = big ? (neg ? r1_m : '0) : shr_v;
        endcase

        // Bit counts within w bits: full-word count less the unused top bits
        cnt_src = (r1_op == OP_CLO) ? (~r1_a & r1_m) : r1_a;
        lz      = lzc_word(cnt_src) + r1_w - WIDTH_W'(DATA_W);
        tz      = lzc_word(bit_rev(r1_a));
        if (tz > r1_w) begin
            tz = r1_w;
        end
        n2_cnt  = (r1_op == OP_CTZ) ? tz : lz;

        // Extract with high index clamped to w-1
        hi_c = (WIDTH_W'(r1_hi) > r1_w - WIDTH_W'(1)) ? r1_w - WIDTH_W'(1)
                                                       : WIDTH_W'(r1_hi);
        lo_w = WIDTH_W'(r1_lo);
        if (lo_w > hi_c) begin
            n2_ext = '0;
            n2_rw  = WIDTH_W'(1);
        end else begin
            n2_ext = r1_a >> r1_lo;
            n2_rw  = hi_c - lo_w + WIDTH_W'(1);
        end

        // Result width for the other classes
        if (r1_op != OP_EXTRACT) begin
            if (r1_op >= OP_REDAND && r1_op <= OP_IMPLIES) begin
                n2_rw = WIDTH_W'(1);
            end else begin
                n2_rw = r1_w;
            end
        end
    end

    logic [OP_W-1:0]    r2_op;
    logic [DATA_W-1:0]  r2_arith, r2_logic, r2_shift, r2_ext;
    logic [WIDTH_W-1:0] r2_cnt, r2_rw;
    logic               r2_flag;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_op    <= r1_op;
            r2_arith <= n2_arith;
            r2_logic <= n2_logic;
            r2_shift <= n2_shift;
            r2_ext   <= n2_ext;
            r2_cnt   <= n2_cnt;
            r2_flag  <= n2_flag;
            r2_rw    <= n2_rw;
        end
    end

    // ---------------- Stage 3: result select and width mask ----------------
    logic [DATA_W-1:0] n3_val;

    always_comb begin
        case (r2_op)
            OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_NEG:
                n3_val = r2_arith;
            OP_NOT, OP_AND, OP_NAND, OP_OR, OP_NOR, OP_XOR, OP_XNOR:
                n3_val = r2_logic;
            OP_SHL, OP_LSHR, OP_ASHR:
                n3_val = r2_shift;
            OP_CLZ, OP_CLO, OP_CTZ:
                n3_val = DATA_W'(r2_cnt);
            OP_EXTRACT:
                n3_val = r2_ext;
            default:
                n3_val = DATA_W'(r2_flag);
        endcase
    end

    logic [DATA_W-1:0]  r3_val;
    logic [WIDTH_W-1:0] r3_rw;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_val <= n3_val & width_mask(r2_rw);
            r3_rw  <= r2_rw;
        end
    end

    assign o_m_tdata = {(M_TDATA_W - M_FIELDS_W)'(0), r3_rw, r3_val};

    // ---------------- Assertions ----------------
    a_rw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r3_rw != '0) && (r3_rw <= WIDTH_W'(MAX_WIDTH)))
        else $error("result width out of range");

    a_val_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((r3_val & ~width_mask(r3_rw)) == '0))
        else $error("result bits set above result width");

    a_s2_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_v && rdy2) |=> r2_v)
        else $error("stage 1 item lost on advance");

    a_s3_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_v && rdy3) |=> r3_v)
        else $error("stage 2 item lost on advance");

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the bit-vector ALU stream unit.
module tb_top;
    import bva_pkg::*;

    localparam int NUM_RANDOM = 1400;
    localparam int NUM_ROWS   = 35;
    localparam int MAX_IDLE   = 12;
    localparam int MAX_REPORT = 100;

    localparam logic [DATA_W-1:0] ONES = '1;
    localparam logic [DATA_W-1:0] MSB  = {1'b1, {(DATA_W-1){1'b0}}};

    // One request; packed from the lowest bit up: op, width, a, b, high, low
    typedef struct packed {
        logic [IDX_W-1:0]   lo;
        logic [IDX_W-1:0]   hi;
        logic [DATA_W-1:0]  b;
        logic [DATA_W-1:0]  a;
        logic [WIDTH_W-1:0] width;
        logic [OP_W-1:0]    op;
    } alu_req_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        logic [DATA_W-1:0]  value;
    } alu_result_t;

    // Directed row: request plus a hand-written answer where it is obvious
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [WIDTH_W-1:0] width;
        logic [DATA_W-1:0]  a;
        logic [DATA_W-1:0]  b;
        logic [IDX_W-1:0]   hi;
        logic [IDX_W-1:0]   lo;
        logic               typed;
        logic [DATA_W-1:0]  exp_value;
        logic [WIDTH_W-1:0] exp_width;
    } vector_row_t;

    localparam vector_row_t VECTOR_ROWS [NUM_ROWS] = '{
        // wraparound at the operand width
        '{OP_ADD,     7'd64,  ONES,       64'd1,    6'd0,  6'd0, 1'b1, 64'd0,    7'd64},
        '{OP_SUB,     7'd64,  64'd0,      64'd1,    6'd0,  6'd0, 1'b1, ONES,     7'd64},
        '{OP_INC,     7'd8,   64'hFF,     64'd0,    6'd0,  6'd0, 1'b1, 64'd0,    7'd8},
        // width zero behaves as one
        '{OP_DEC,     7'd0,   64'd0,      64'd0,    6'd0,  6'd0, 1'b1, 64'd1,    7'd1},
        // width above the maximum behaves as the maximum
        '{OP_NOT,     7'd127, 64'd0,      64'd0,    6'd0,  6'd0, 1'b1, ONES,     7'd64},
        '{OP_NEG,     7'd64,  MSB,        64'd0,    6'd0,  6'd0, 1'b1, MSB,      7'd64},
        // operand bits above the width are dropped
        '{OP_AND,     7'd16,  ONES,       ONES,     6'd0,  6'd0, 1'b1, 64'hFFFF, 7'd16},
        '{OP_NAND,    7'd1,   64'd1,      64'd1,    6'd0,  6'd0, 1'b1, 64'd0,    7'd1},
        '{OP_OR,      7'd64,  64'd0,      64'd0,    6'd0,  6'd0, 1'b1, 64'd0,    7'd64},
        '{OP_NOR,     7'd64,  64'd0,      64'd0,    6'd0,  6'd0, 1'b1, ONES,     7'd64},
        '{OP_XOR,     7'd32,  64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                              6'd0,  6'd0, 1'b0, 64'd0, 7'd0},
        '{OP_XNOR,    7'd7,   64'h55,     64'h2A,   6'd0,  6'd0, 1'b0, 64'd0,    7'd0},
        '{OP_REDAND,  7'd64,  ONES,       64'd0,    6'd0,  6'd0, 1'b1, 64'd1,    7'd1},
        '{OP_REDOR,   7'd64,  64'd0,      64'd0,    6'd0,  6'd0, 1'b1, 64'd0,    7'd1},
        '{OP_ULT,     7'd64,  64'd0,      ONES,     6'd0,  6'd0, 1'b1, 64'd1,    7'd1},
        '{OP_ULE,     7'd64,  ONES,       ONES,     6'd0,  6'd0, 1'b1, 64'd1,    7'd1},
        '{OP_UGT,     7'd8,   64'h80,     64'h7F,   6'd0,  6'd0, 1'b1, 64'd1,    7'd1},
        '{OP_UGE,     7'd8,   64'd0,      64'd1,    6'd0,  6'd0, 1'b1, 64'd0,    7'd1},
        '{OP_SLT,     7'd8,   64'h80,     64'h7F,   6'd0,  6'd0, 1'b1, 64'd1,    7'd1},
        '{OP_SLE,     7'd64,  MSB,        ~MSB,     6'd0,  6'd0, 1'b1, 64'd1,    7'd1},
        '{OP_SGT,     7'd1,   64'd0,      64'd1,    6'd0,  6'd0, 1'b1, 64'd1,    7'd1},
        '{OP_SGE,     7'd64,  ~MSB,       MSB,      6'd0,  6'd0, 1'b1, 64'd1,    7'd1},
        '{OP_EQ,      7'd64,  ONES,       ONES,     6'd0,  6'd0, 1'b1, 64'd1,    7'd1},
        '{OP_NE,      7'd4,   64'h10,     64'd0,    6'd0,  6'd0, 1'b1, 64'd0,    7'd1},
        // implies looks at bit 0 only
        '{OP_IMPLIES, 7'd64,  ONES,       ~64'd1,   6'd0,  6'd0, 1'b1, 64'd0,    7'd1},
        // shift by the full width clears, or fills with ones for a negative ASHR
        '{OP_SHL,     7'd64,  64'd1,      64'd64,   6'd0,  6'd0, 1'b1, 64'd0,    7'd64},
        '{OP_LSHR,    7'd16,  64'hFFFF,   64'd15,   6'd0,  6'd0, 1'b1, 64'd1,    7'd16},
        '{OP_ASHR,    7'd8,   64'h80,     64'd200,  6'd0,  6'd0, 1'b1, 64'hFF,   7'd8},
        '{OP_ASHR,    7'd64,  MSB,        64'd63,   6'd0,  6'd0, 1'b0, 64'd0,    7'd0},
        // counts of an all-zero or all-one operand give the width
        '{OP_CLZ,     7'd64,  64'd0,      64'd0,    6'd0,  6'd0, 1'b1, 64'd64,   7'd64},
        '{OP_CLO,     7'd64,  ONES,       64'd0,    6'd0,  6'd0, 1'b1, 64'd64,   7'd64},
        '{OP_CTZ,     7'd1,   64'd0,      64'd0,    6'd0,  6'd0, 1'b1, 64'd1,    7'd1},
        '{OP_EXTRACT, 7'd64,  ONES,       64'd0,    6'd63, 6'd0, 1'b1, ONES,     7'd64},
        // high clamped to w-1, then low above high
        '{OP_EXTRACT, 7'd8,   ONES,       64'd0,    6'd63, 6'd8, 1'b1, 64'd0,    7'd1},
        '{OP_EXTRACT, 7'd64,  ONES,       64'd0,    6'd3,  6'd5, 1'b1, 64'd0,    7'd1}
    };

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;

    alu_result_t pending_results [$];
    int          error_count   = 0;
    int          ops_sent      = 0;
    int          results_seen  = 0;
    logic [31:0] ops_seen      = '0;
    int          next_gap      = 0;
    int          stall_left    = 0;
    bit          tx_no_gap     = 1'b0;
    bit          rx_no_stall   = 1'b0;

    bitvector_alu_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("timeout: %0d results still outstanding", pending_results.size());
        $display("tb_top NOT OK");
        $finish;
    end

    // Low n bits set
    function automatic logic [DATA_W-1:0] low_ones(input int unsigned n);
        return (n >= DATA_W) ? ONES : ((64'd1 << n) - 64'd1);
    endfunction

    // Expected value and width of one ALU operation
    function automatic alu_result_t bitvector_result(input alu_req_t req);
        int unsigned       w;
        int unsigned       rw;
        int unsigned       n;
        int unsigned       hi;
        logic [DATA_W-1:0] m;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] sa;
        logic [DATA_W-1:0] sb;
        logic [DATA_W-1:0] r;
        alu_result_t       res;
        w = req.width;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        m  = low_ones(w);
        a  = req.a & m;
        b  = req.b & m;
        rw = w;
        n  = 0;
        r  = '0;
        // flip the sign bit so signed order becomes unsigned order
        sa = a ^ (64'd1 << (w - 1));
        sb = b ^ (64'd1 << (w - 1));
        case (req.op)
            OP_ADD:     r = a + b;
            OP_SUB:     r = a - b;
            OP_INC:     r = a + 64'd1;
            OP_DEC:     r = a - 64'd1;
            OP_NOT:     r = ~a;
            OP_NEG:     r = 64'd0 - a;
            OP_AND:     r = a & b;
            OP_NAND:    r = ~(a & b);
            OP_OR:      r = a | b;
            OP_NOR:     r = ~(a | b);
            OP_XOR:     r = a ^ b;
            OP_XNOR:    r = ~(a ^ b);
            OP_REDAND:  begin r = 64'(a == m);  rw = 1; end
            OP_REDOR:   begin r = 64'(a != 0);  rw = 1; end
            OP_ULT:     begin r = 64'(a < b);   rw = 1; end
            OP_ULE:     begin r = 64'(a <= b);  rw = 1; end
            OP_UGT:     begin r = 64'(a > b);   rw = 1; end
            OP_UGE:     begin r = 64'(a >= b);  rw = 1; end
            OP_SLT:     begin r = 64'(sa < sb); rw = 1; end
            OP_SLE:     begin r = 64'(sa <= sb); rw = 1; end
            OP_SGT:     begin r = 64'(sa > sb); rw = 1; end
            OP_SGE:     begin r = 64'(sa >= sb); rw = 1; end
            OP_EQ:      begin r = 64'(a == b);  rw = 1; end
            OP_NE:      begin r = 64'(a != b);  rw = 1; end
            OP_IMPLIES: begin r = 64'(!a[0] || b[0]); rw = 1; end
            OP_SHL:     r = (b >= 64'(w)) ? 64'd0 : (a << b);
            OP_LSHR:    r = (b >= 64'(w)) ? 64'd0 : (a >> b);
            OP_ASHR: begin
                if (a[w-1]) begin
                    r = (b >= 64'(w)) ? m : ~((~a & m) >> b);
                end else begin
                    r = (b >= 64'(w)) ? 64'd0 : (a >> b);
                end
            end
            OP_CLZ: begin
                while (n < w && !a[w-1-n]) n++;
                r = 64'(n);
            end
            OP_CLO: begin
                while (n < w && a[w-1-n]) n++;
                r = 64'(n);
            end
            OP_CTZ: begin
                while (n < w && !a[n]) n++;
                r = 64'(n);
            end
            default: begin
                // bit-field extract
                hi = req.hi;
                if (hi > w - 1) hi = w - 1;
                if (req.lo > hi) begin
                    r  = 64'd0;
                    rw = 1;
                end else begin
                    rw = hi - req.lo + 1;
                    r  = a >> req.lo;
                end
            end
        endcase
        res.value = r & low_ones(rw);
        res.width = WIDTH_W'(rw);
        return res;
    endfunction

    // Random operand: edge patterns, counted runs, or noise; mostly clean above width
    function automatic logic [DATA_W-1:0] random_operand(input int unsigned w);
        logic [DATA_W-1:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: r = '0;
            1: r = ONES;
            2: r = 64'd1 << $urandom_range(0, 63);
            3: r = ~(64'd1 << $urandom_range(0, 63));
            4: r = r >> $urandom_range(0, 63);
            5: r = ~(r >> $urandom_range(0, 63));
            6: r = r << $urandom_range(0, 63);
            default: ;
        endcase
        if ($urandom_range(0, 3) != 0) r &= low_ones(w);
        return r;
    endfunction

    function automatic alu_req_t random_request();
        alu_req_t    req;
        int unsigned w;
        case ($urandom_range(0, 9))
            0:       req.width = 7'd1;
            1:       req.width = 7'd64;
            2:       req.width = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127));
            3:       req.width = 7'($urandom_range(1, 8));
            default: req.width = 7'($urandom_range(1, 64));
        endcase
        w = (req.width == 0) ? 1 : (req.width > MAX_WIDTH) ? MAX_WIDTH : req.width;
        req.op = 5'($urandom_range(0, 31));
        req.a  = random_operand(w);
        // shift amounts mostly from zero to two past the width
        if ((req.op == OP_SHL || req.op == OP_LSHR || req.op == OP_ASHR)
            && $urandom_range(0, 3) != 0) begin
            req.b = 64'($urandom_range(0, w + 2));
        end else begin
            req.b = random_operand(w);
        end
        case ($urandom_range(0, 3))
            0: begin
                req.hi = 6'($urandom_range(0, 63));
                req.lo = 6'($urandom_range(0, 63));
            end
            1: begin
                req.hi = 6'($urandom_range(0, w - 1));
                req.lo = 6'($urandom_range(0, req.hi));
            end
            default: begin
                req.hi = 6'($urandom_range(0, 63));
                req.lo = 6'($urandom_range(0, req.hi));
            end
        endcase
        return req;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (error_count < MAX_REPORT)
            $display("mismatch on %s at result %0d: got %h, expected %h",
                     what, results_seen, got, want);
        error_count++;
    endtask

    // Drive one request and wait for its transaction
    task automatic send_request(input alu_req_t req, input bit typed,
                                input alu_result_t typed_result);
        repeat (next_gap) @(posedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= req;
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(typed ? typed_result : bitvector_result(req));
        ops_sent++;
        ops_seen[req.op] = 1'b1;
        next_gap = tx_no_gap ? 0 : $urandom_range(0, MAX_IDLE);
        if (next_gap != 0) i_s_tvalid <= 1'b0;
    endtask

    // Stop sending until every outstanding result has come back
    task automatic drain_results();
        if (next_gap == 0) i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Result side: check each transaction, then draw the next stall
    always @(posedge i_clk) begin
        alu_result_t want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", o_m_tdata[DATA_W-1:0], '0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_m_tdata[DATA_W-1:0] !== want.value)
                        report_mismatch("result_value", o_m_tdata[DATA_W-1:0], want.value);
                    if (o_m_tdata[M_FIELDS_W-1:DATA_W] !== want.width)
                        report_mismatch("result_width", 64'(o_m_tdata[M_FIELDS_W-1:DATA_W]),
                                        64'(want.width));
                    if (o_m_tdata[M_TDATA_W-1:M_FIELDS_W] !== '0)
                        report_mismatch("padding", 64'(o_m_tdata[M_TDATA_W-1:M_FIELDS_W]),
                                        64'd0);
                end
                results_seen++;
                stall_left = rx_no_stall ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial begin
        alu_req_t    req;
        alu_result_t typed_result;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (VECTOR_ROWS[i]) begin
            req.op             = VECTOR_ROWS[i].op;
            req.width          = VECTOR_ROWS[i].width;
            req.a              = VECTOR_ROWS[i].a;
            req.b              = VECTOR_ROWS[i].b;
            req.hi             = VECTOR_ROWS[i].hi;
            req.lo             = VECTOR_ROWS[i].lo;
            typed_result.value = VECTOR_ROWS[i].exp_value;
            typed_result.width = VECTOR_ROWS[i].exp_width;
            send_request(req, VECTOR_ROWS[i].typed, typed_result);
        end
        drain_results();

        // random part, with stretches of back-to-back traffic on either side
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i % 100 == 0) begin
                tx_no_gap   = ($urandom_range(0, 2) == 0);
                rx_no_stall = ($urandom_range(0, 2) == 0);
            end
            if (i == NUM_RANDOM / 2) drain_results();
            send_request(random_request(), 1'b0, '0);
        end

        drain_results();
        repeat (8) @(posedge i_clk);

        $display("%0d operations sent (%0d from the table), %0d results checked",
                 ops_sent, NUM_ROWS, results_seen);
        $display("%0d of 32 opcodes exercised, widths 0 to 127, random stalls on both sides",
                 $countones(ops_seen));
        if (error_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("%0d mismatches", error_count);
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// File: bitvector_alu_unit.f
src/bva_pkg.sv
src/bitvector_alu_unit.sv
dv/tb_top.sv
